FILE: rtl/pre_pkg.sv
package pre_pkg;

  localparam int unsigned Pages     = 64;
  localparam int unsigned Frames    = 64;
  localparam int unsigned TimeBits  = 16;
  localparam int unsigned PageBits  = $clog2(Pages);
  localparam int unsigned FrameBits = $clog2(Frames);
  localparam int unsigned LevelBits = $clog2(Frames + 1);
  localparam int unsigned ScanBits  = 7;

  localparam logic [1:0] KindAccess  = 2'd0;
  localparam logic [1:0] KindPush    = 2'd1;
  localparam logic [1:0] KindPreload = 2'd2;

  localparam logic [1:0] PolicyLru = 2'd1;
  localparam logic [1:0] PolicyLfu = 2'd2;

  localparam logic [2:0] StatusHit      = 3'd0;
  localparam logic [2:0] StatusFaultQ   = 3'd1;
  localparam logic [2:0] StatusEvict    = 3'd2;
  localparam logic [2:0] StatusNone     = 3'd3;
  localparam logic [2:0] StatusAccepted = 3'd4;
  localparam logic [2:0] StatusFull     = 3'd5;

  localparam logic [0:0] RegPolicy = 1'd0;
  localparam logic [0:0] RegPages  = 1'd1;

  typedef struct packed {
    logic [1:0]          kind;
    logic [PageBits-1:0] page;
    logic [TimeBits-1:0] stamp;
    logic [FrameBits-1:0] frame_in;
    logic [TimeBits-1:0] last_use_in;
    logic [15:0]         uses_in;
  } req_t;

  typedef struct packed {
    logic [FrameBits-1:0] frame_out;
    logic [2:0]           status;
    logic [PageBits-1:0]  evicted_page;
    logic [31:0]          fault_total;
  } rsp_t;

  typedef struct packed {
    logic [FrameBits-1:0] frame;
    logic [TimeBits-1:0]  arrival;
    logic [TimeBits-1:0]  last_use;
    logic [15:0]          uses;
  } entry_t;

endpackage

FILE: rtl/page_replacement_engine.sv
// Page replacement engine: page table in a synchronous memory, one entry read a cycle.
// Push, preload and refused items finish in StRead; a hit goes on to StDec and a fault
// with a free frame in the queue to StQwait; a fault with an empty queue scans
// min(pages_in_use, 64) page entries in StScan, one a cycle, then installs in StFin.
// Throughput: one item at a time; the next one is accepted in the result cycle.
// Reset (rst_ni low, async) inits valid bits, queue pointers, counter, state, config.
module page_replacement_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  pre_pkg::req_t        req_i,
  output logic                 done_o,
  output pre_pkg::rsp_t        rsp_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  // Table and queue contents stay undefined until written; the receiver cannot
  // stall, so each result is shown for one cycle on done_o.

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRead  = 3'd1; // table read in flight
  localparam logic [2:0] StDec   = 3'd2; // decide on the entry
  localparam logic [2:0] StScan  = 3'd3; // victim scan
  localparam logic [2:0] StFin   = 3'd4; // install after scan
  localparam logic [2:0] StQwait = 3'd5; // queue head read

  logic [2:0] state_q, state_d;

  // configuration
  logic [1:0]                 policy_q;
  logic [pre_pkg::ScanBits-1:0] pages_q;
  logic                       cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= '0;
      pages_q  <= pre_pkg::ScanBits'(pre_pkg::Pages);
    end else if (cfg_wr && paddr[1:0] == 2'b00 && paddr[2] == pre_pkg::RegPolicy) begin
      policy_q <= pwdata[1:0];
    end else if (cfg_wr && paddr[1:0] == 2'b00 && paddr[2] == pre_pkg::RegPages) begin
      pages_q <= pwdata[pre_pkg::ScanBits-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == pre_pkg::RegPolicy) begin
      prdata[1:0] = policy_q;
    end else begin
      prdata[pre_pkg::ScanBits-1:0] = pages_q;
    end
  end

  // item registers
  pre_pkg::req_t req_q;
  logic [pre_pkg::Pages-1:0] valid_q, valid_d;
  logic [31:0] faults_q, faults_d;
  logic        done_q, done_d;
  pre_pkg::rsp_t rsp_q, rsp_d;

  // scan state
  logic [pre_pkg::ScanBits-1:0] idx_q, idx_d;     // address issued
  logic [pre_pkg::PageBits-1:0] cmp_q, cmp_d;     // page whose data arrives
  logic                         cmpv_q, cmpv_d;
  logic                         found_q, found_d;
  logic [pre_pkg::PageBits-1:0] best_q, best_d;
  pre_pkg::entry_t              bent_q, bent_d;
  logic [pre_pkg::ScanBits-1:0] limit;

  // table port
  logic                         tw_en;
  logic [pre_pkg::PageBits-1:0] tw_addr, tr_addr;
  pre_pkg::entry_t              tw_data, tr_data;

  // queue port
  logic                         q_push, q_pop;
  logic [pre_pkg::FrameBits-1:0] q_head;
  logic [pre_pkg::LevelBits-1:0] q_level;

  pre_page_table u_table (
    .clk_i   (clk_i),
    .we_i    (tw_en),
    .waddr_i (tw_addr),
    .wdata_i (tw_data),
    .raddr_i (tr_addr),
    .rdata_o (tr_data)
  );

  pre_free_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_frame_i (req_q.frame_in),
    .pop_i        (q_pop),
    .head_frame_o (q_head),
    .level_o      (q_level)
  );

  assign limit = (pages_q > pre_pkg::ScanBits'(pre_pkg::Pages))
               ? pre_pkg::ScanBits'(pre_pkg::Pages) : pages_q;

  // candidate better than current best
  logic better;
  always_comb begin
    case (policy_q)
      pre_pkg::PolicyLru: better = tr_data.last_use < bent_q.last_use;
      pre_pkg::PolicyLfu: better = (tr_data.uses < bent_q.uses) ||
                                   (tr_data.uses == bent_q.uses &&
                                    tr_data.arrival < bent_q.arrival);
      default:            better = tr_data.arrival < bent_q.arrival;
    endcase
  end

  pre_pkg::entry_t fresh;
  always_comb begin
    fresh.frame    = '0;
    fresh.arrival  = req_q.stamp;
    fresh.last_use = req_q.stamp;
    fresh.uses     = 16'd1;
  end

  always_comb begin
    state_d  = state_q;
    valid_d  = valid_q;
    faults_d = faults_q;
    done_d   = 1'b0;
    rsp_d    = rsp_q;
    idx_d    = idx_q;
    cmp_d    = cmp_q;
    cmpv_d   = 1'b0;
    found_d  = found_q;
    best_d   = best_q;
    bent_d   = bent_q;
    tw_en    = 1'b0;
    tw_addr  = req_q.page;
    tw_data  = fresh;
    tr_addr  = req_q.page;
    q_push   = 1'b0;
    q_pop    = 1'b0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          state_d = StRead;
        end
      end
      StRead: begin
        rsp_d = '0;
        rsp_d.status = pre_pkg::StatusNone;
        case (req_q.kind)
          pre_pkg::KindAccess: begin
            if (valid_q[req_q.page]) begin
              state_d = StDec;
            end else begin
              faults_d = faults_q + 32'd1;
              if (q_level != '0) begin
                state_d = StQwait;
              end else begin
                idx_d   = '0;
                found_d = 1'b0;
                state_d = StScan;
              end
            end
          end
          pre_pkg::KindPush: begin
            if (q_level >= pre_pkg::LevelBits'(pre_pkg::Frames)) begin
              rsp_d.status = pre_pkg::StatusFull;
            end else begin
              q_push = 1'b1;
              rsp_d.status = pre_pkg::StatusAccepted;
            end
            done_d  = 1'b1;
            state_d = StIdle;
          end
          pre_pkg::KindPreload: begin
            tw_en            = 1'b1;
            tw_data.frame    = req_q.frame_in;
            tw_data.arrival  = req_q.stamp;
            tw_data.last_use = req_q.last_use_in;
            tw_data.uses     = req_q.uses_in;
            valid_d[req_q.page] = 1'b1;
            rsp_d.status = pre_pkg::StatusAccepted;
            done_d  = 1'b1;
            state_d = StIdle;
          end
          default: begin
            done_d  = 1'b1;
            state_d = StIdle;
          end
        endcase
        rsp_d.fault_total = faults_d;
      end
      StDec: begin
        // hit: entry read data valid now
        tw_en            = 1'b1;
        tw_data          = tr_data;
        tw_data.last_use = req_q.stamp;
        if (tr_data.uses != 16'hFFFF) begin
          tw_data.uses = tr_data.uses + 16'd1;
        end
        rsp_d.frame_out = tr_data.frame;
        rsp_d.status    = pre_pkg::StatusHit;
        done_d  = 1'b1;
        state_d = StIdle;
      end
      StQwait: begin
        q_pop         = 1'b1;
        tw_en         = 1'b1;
        tw_data.frame = q_head;
        valid_d[req_q.page] = 1'b1;
        rsp_d.frame_out = q_head;
        rsp_d.status    = pre_pkg::StatusFaultQ;
        done_d  = 1'b1;
        state_d = StIdle;
      end
      StScan: begin
        // issue next address, compare data of previous one
        tr_addr = idx_q[pre_pkg::PageBits-1:0];
        if (cmpv_q && valid_q[cmp_q]) begin
          if (!found_q || better) begin
            found_d = 1'b1;
            best_d  = cmp_q;
            bent_d  = tr_data;
          end
        end
        if (idx_q < limit) begin
          cmp_d  = idx_q[pre_pkg::PageBits-1:0];
          cmpv_d = 1'b1;
          idx_d  = idx_q + 1'b1;
        end else if (!cmpv_q) begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (found_q) begin
          tw_en         = 1'b1;
          tw_data.frame = bent_q.frame;
          valid_d[best_q]     = 1'b0;
          valid_d[req_q.page] = 1'b1;
          rsp_d.frame_out    = bent_q.frame;
          rsp_d.evicted_page = best_q;
          rsp_d.status       = pre_pkg::StatusEvict;
        end
        done_d  = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      valid_q  <= '0;
      faults_q <= '0;
      done_q   <= 1'b0;
      cmpv_q   <= 1'b0;
      found_q  <= 1'b0;
      idx_q    <= '0;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      faults_q <= faults_d;
      done_q   <= done_d;
      cmpv_q   <= cmpv_d;
      found_q  <= found_d;
      idx_q    <= idx_d;
    end
  end

  // payload: hold item, result and scan data
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start_i) begin
      req_q <= req_i;
    end
    rsp_q  <= rsp_d;
    cmp_q  <= cmp_d;
    best_q <= best_d;
    bent_q <= bent_d;
  end

  assign busy_o = (state_q != StIdle);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !$past(state_q == StIdle)) else $error("result without item");
  a_idle_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> state_q == StIdle) else $error("still busy at result");
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StScan |-> idx_q <= limit) else $error("scan overran");
`endif

endmodule

FILE: rtl/pre_free_queue.sv
module pre_free_queue (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  input  logic [pre_pkg::FrameBits-1:0]   push_frame_i,
  input  logic                            pop_i,
  output logic [pre_pkg::FrameBits-1:0]   head_frame_o,
  output logic [pre_pkg::LevelBits-1:0]   level_o
);

  logic [pre_pkg::FrameBits-1:0] mem [pre_pkg::Frames];
  logic [pre_pkg::FrameBits-1:0] head_q, head_d;
  logic [pre_pkg::LevelBits-1:0] level_q, level_d;
  logic [pre_pkg::FrameBits-1:0] tail;

  assign tail = head_q + level_q[pre_pkg::FrameBits-1:0];

  always_comb begin
    head_d  = head_q;
    level_d = level_q;
    if (push_i) begin
      level_d = level_q + 1'b1;
    end
    if (pop_i) begin
      head_d  = head_q + 1'b1;
      level_d = level_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      level_q <= '0;
    end else begin
      head_q  <= head_d;
      level_q <= level_d;
    end
  end

  // read data is the current head; registered
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[tail] <= push_frame_i;
    end
    head_frame_o <= mem[head_q];
  end

  assign level_o = level_q;

endmodule

FILE: rtl/pre_page_table.sv
module pre_page_table (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [pre_pkg::PageBits-1:0]   waddr_i,
  input  pre_pkg::entry_t                wdata_i,
  input  logic [pre_pkg::PageBits-1:0]   raddr_i,
  output pre_pkg::entry_t                rdata_o
);

  pre_pkg::entry_t mem [pre_pkg::Pages];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
